// ----- src/msbw_pkg.sv -----
// Shared types and constants for the MSB-first bit writer.
package msbw_pkg;

	localparam int ACC_BITS    = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ACT_UBITS = 3'd0;
	localparam logic [2:0] ACT_SBITS = 3'd1;
	localparam logic [2:0] ACT_FLUSH = 3'd2;
	localparam logic [2:0] ACT_BYTE  = 3'd3;
	localparam logic [2:0] ACT_WORD  = 3'd4;
	localparam logic [2:0] ACT_DWORD = 3'd5;

	// One emit job: bytes leave from word[31:24] downward.
	typedef struct packed {
		logic [ACC_BITS-1:0] word;
		logic [2:0]          nbytes;
	} job_t;

endpackage

// ----- src/msbw_front.sv -----
// Front end: bit accumulator, classifies each item into an emit job.
module msbw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [2:0]            action,
	input  logic [5:0]            field_width,
	input  logic [31:0]           value,
	output logic                  push,
	output msbw_pkg::job_t        job
);

	logic [31:0] acc_q;
	logic [5:0]  cnt_q;

	logic [31:0] acc_d;
	logic [5:0]  cnt_d;
	logic [5:0]  n;
	logic [63:0] mask64;
	logic [31:0] vm;
	logic [6:0]  total;
	logic [5:0]  spill;
	logic [63:0] ext;
	logic [63:0] spill_lo;
	logic [63:0] spill_hi;
	logic [63:0] aligned;

	always_comb begin
		n        = (field_width > 6'd32) ? 6'd32 : field_width;
		mask64   = ~(64'hFFFF_FFFF_FFFF_FFFF << n);
		vm       = value & mask64[31:0];
		total    = {1'b0, cnt_q} + {1'b0, n};
		spill    = 6'(total - 7'd32);
		ext      = {32'd0, vm};
		spill_lo = ext >> spill;
		spill_hi = ext << (6'd32 - spill);
		aligned  = ext << (6'd32 - n);

		acc_d      = acc_q;
		cnt_d      = cnt_q;
		job.word   = acc_q;
		job.nbytes = 3'd0;

		case (action)
			msbw_pkg::ACT_UBITS, msbw_pkg::ACT_SBITS: begin
				if (n != 6'd0) begin
					if (total > 7'd32) begin
						// overflow: full word goes out, residue stays left aligned
						job.word   = acc_q | spill_lo[31:0];
						job.nbytes = 3'd4;
						acc_d      = spill_hi[31:0];
						cnt_d      = spill;
					end else begin
						acc_d = acc_q | (aligned[31:0] >> cnt_q);
						cnt_d = total[5:0];
					end
				end
			end
			msbw_pkg::ACT_FLUSH: begin
				job.nbytes = 3'((7'({1'b0, cnt_q}) + 7'd7) >> 3);
				acc_d      = 32'd0;
				cnt_d      = 6'd0;
			end
			msbw_pkg::ACT_BYTE: begin
				job.word   = {value[7:0], 24'd0};
				job.nbytes = 3'd1;
				acc_d      = 32'd0;
				cnt_d      = 6'd0;
			end
			msbw_pkg::ACT_WORD: begin
				job.word   = {value[7:0], value[15:8], 16'd0};
				job.nbytes = 3'd2;
				acc_d      = 32'd0;
				cnt_d      = 6'd0;
			end
			msbw_pkg::ACT_DWORD: begin
				job.word   = {value[7:0], value[15:8], value[23:16], value[31:24]};
				job.nbytes = 3'd4;
				acc_d      = 32'd0;
				cnt_d      = 6'd0;
			end
			default: begin
			end
		endcase
	end

	assign push = accept && (job.nbytes != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
			cnt_q <= 6'd0;
		end else if (accept) begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
		end
	end

endmodule

// ----- src/msbw_queue.sv -----
// Short job queue between front and back.
module msbw_queue #(
	parameter int DEPTH = msbw_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  msbw_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output msbw_pkg::job_t pop_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	msbw_pkg::job_t     mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CW-1:0]      count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- src/msbw_back.sv -----
// Back end: serializes jobs into bytes behind an output register.
module msbw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	input  msbw_pkg::job_t job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last
);

	logic [31:0] word_q;
	logic [2:0]  left_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        emit;

	assign emit = (left_q != 3'd0) && (!out_valid_q || out_ready);
	// next job loads as the current one hands over its final byte
	assign pop  = job_valid && ((left_q == 3'd0) || ((left_q == 3'd1) && emit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				left_q <= job.nbytes;
			end else if (emit) begin
				left_q <= left_q - 3'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= job.word;
		end else if (emit) begin
			word_q <= {word_q[23:0], 8'd0};
		end
		if (emit) begin
			out_byte_q <= word_q[31:24];
			last_q     <= (left_q == 3'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

// ----- src/msb_first_bit_writer_core.sv -----
// MSB-first bit writer: top level joining front end, job queue and byte serializer.
// Path: job queue, serializer word register, then output byte register.
// Throughput: one item per cycle while the job queue has room; the serializer
// sends one byte per cycle while out_ready is high, and takes one job at a time.
// Items that emit nothing only update the accumulator and push no job.
// Reset: arst_n clears accumulator, pending count, queue and output valid.
module msb_first_bit_writer_core #(
	parameter int QUEUE_DEPTH = msbw_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [5:0]  field_width,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic           accept;
	logic           push;
	logic           full;
	logic           pop;
	logic           job_valid;
	msbw_pkg::job_t push_job;
	msbw_pkg::job_t pop_job;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	msbw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.field_width (field_width),
		.value       (value),
		.push        (push),
		.job         (push_job)
	);

	msbw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.pop_valid (job_valid),
		.pop_job   (pop_job)
	);

	msbw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (pop_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
